// ----- src/lwes_pkg.sv -----
`timescale 1ns / 1ps

package lwes_pkg;

    localparam int WINDOW_LEN_DEF  = 10;
    localparam int MAX_SEGMENT_DEF = 32768;

    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 15;
    localparam int NEEDED_W = 4;
    localparam int SHIFT_W  = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd500;
    localparam logic [NEEDED_W-1:0] NEEDED_RESET = 4'd4;
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX    = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_NEEDED    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       scan_from_end;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        t_status            status;
    } t_out_item;

endpackage

// ----- src/loud_window_edge_search.sv -----
`timescale 1ns / 1ps

// Loud-window edge search over a segment of 16-bit audio samples.
// Input channel: one sample per transfer (i_in_valid / o_in_stall); the
// transfer with last set ends the segment. The first transfer of a segment
// sets the search direction. Output channel: one result per segment
// (o_out_valid / i_out_stall), holding the shift and a status code.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 amplitude limit, 1 count needed); write only while the block is idle.
// The final sample passes through the input register and then the result
// register before its result is presented.
// Throughput: one sample per cycle unless the input side stalls; the loud
// count, history shift register and hit tracking are updated in between.
// When the receiver stalls, the result register holds; a later final
// sample then waits in the input register and the input side stalls, while
// samples that end no segment keep flowing through.
// Reset (synchronous, active low) empties both registers, clears the
// segment state and restores the registers to 500 and 4.
module loud_window_edge_search
    import lwes_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_SEGMENT + 1);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam logic [IDX_W-1:0] WIN_IDX = IDX_W'(WINDOW_LEN);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SEGMENT);

    logic [LIMIT_W-1:0]  r_limit;
    logic [NEEDED_W-1:0] r_needed;

    logic     r_in_valid;
    t_in_item r_in;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic [WINDOW_LEN-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_hit, n_hit;
    logic                  r_hit_valid, n_hit_valid;
    logic                  r_dir, n_dir;

    logic advance;
    logic in_take;

    // Input register can move on unless it holds a final sample and the
    // result register is still occupied.
    assign advance    = r_in_valid && (!r_in.last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        logic                  dir_eff;
        logic                  take;
        logic signed [16:0]    s_ext;
        logic signed [16:0]    lim_ext;
        logic                  loud;
        logic [WINDOW_LEN-1:0] hist_upd;
        logic [CNT_W-1:0]      cnt_upd;
        logic [IDX_W-1:0]      idx_upd;
        logic                  qualify;
        logic [IDX_W-1:0]      seg_idx;
        logic [IDX_W-1:0]      seg_hit;
        logic                  seg_hit_valid;
        logic [IDX_W-1:0]      base;
        logic                  found;
        logic [IDX_W-1:0]      value;

        dir_eff  = (r_idx == '0) ? r_in.scan_from_end : r_dir;
        take     = r_idx < MAX_IDX;
        s_ext    = {r_in.sample[SAMPLE_W-1], r_in.sample};
        lim_ext  = $signed({2'b00, r_limit});
        loud     = (s_ext > lim_ext) || (s_ext < -lim_ext);
        hist_upd = {loud, r_hist[WINDOW_LEN-1:1]};
        cnt_upd  = r_cnt - CNT_W'(r_hist[0]) + CNT_W'(loud);
        idx_upd  = r_idx + IDX_W'(1);
        qualify  = (idx_upd >= WIN_IDX) && (32'(cnt_upd) > 32'(r_needed));

        seg_idx       = take ? idx_upd : r_idx;
        seg_hit       = r_hit;
        seg_hit_valid = r_hit_valid;
        if (take && qualify && (dir_eff || !r_hit_valid)) begin
            seg_hit       = idx_upd - WIN_IDX;
            seg_hit_valid = 1'b1;
        end

        base  = seg_idx - WIN_IDX;
        found = dir_eff ? (seg_hit_valid && seg_hit <= base)
                        : (seg_hit_valid && seg_hit < base);
        if (!found) begin
            value = base;
        end else if (dir_eff) begin
            value = base - seg_hit;
        end else begin
            value = seg_hit;
        end

        if (seg_idx < WIN_IDX) begin
            n_out.shift  = '0;
            n_out.status = STATUS_SHORT;
        end else begin
            n_out.shift  = (32'(value) > 32'(SHIFT_MAX)) ? SHIFT_MAX : SHIFT_W'(value);
            n_out.status = found ? STATUS_FOUND : STATUS_NONE;
        end

        // A final sample returns the segment state to its cleared form.
        if (r_in.last) begin
            n_hist      = '0;
            n_cnt       = '0;
            n_idx       = '0;
            n_hit       = '0;
            n_hit_valid = 1'b0;
            n_dir       = 1'b0;
        end else begin
            n_hist      = take ? hist_upd : r_hist;
            n_cnt       = take ? cnt_upd : r_cnt;
            n_idx       = seg_idx;
            n_hit       = seg_hit;
            n_hit_valid = seg_hit_valid;
            n_dir       = dir_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_needed <= NEEDED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AMPLITUDE_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_COUNT_NEEDED:    r_needed <= i_cfg_data[NEEDED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_hit       <= '0;
            r_hit_valid <= 1'b0;
            r_dir       <= 1'b0;
        end else if (advance) begin
            r_hist      <= n_hist;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_hit_valid <= n_hit_valid;
            r_dir       <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The running loud count always equals the flags held in the history.
    a_count_matches_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) == $countones(r_hist))
        else $error("loud count differs from history");

    // A recorded hit is always a window that has fully arrived.
    a_hit_within_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_valid |-> (32'(r_hit) + 32'(WINDOW_LEN) <= 32'(r_idx)))
        else $error("hit start beyond received samples");

    // The segment length never passes the maximum.
    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= MAX_IDX)
        else $error("segment index overflow");

    // Finishing a segment clears its state and presents a result.
    a_segment_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last) |=> (r_idx == '0 && !r_hit_valid && r_out_valid))
        else $error("segment not closed after final sample");

endmodule
